// File: hdl/ppmfd_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Widths, register indexes, reset values and helpers for the PPM decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

   // Field widths.
   localparam int TIME_W    = 16;
   localparam int CHAN_OUT_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int PROD_W    = 2 * TIME_W;
   localparam int SUM_W     = PROD_W + 2;

   // Default number of channels in one frame.
   localparam int NUM_CHANNELS_DEF = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_LOW    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_HIGH   = 3'd7;

   // Register reset values.
   localparam logic [TIME_W-1:0]        COUNT_MIN_RST  = 16'd1000;
   localparam logic [TIME_W-1:0]        COUNT_MAX_RST  = 16'd2000;
   localparam logic signed [TIME_W-1:0] ROLL_LOW_RST   = -16'sd30;
   localparam logic signed [TIME_W-1:0] ROLL_HIGH_RST  = 16'sd30;
   localparam logic signed [TIME_W-1:0] PITCH_LOW_RST  = -16'sd30;
   localparam logic signed [TIME_W-1:0] PITCH_HIGH_RST = 16'sd30;
   localparam logic signed [TIME_W-1:0] YAW_LOW_RST    = -16'sd180;
   localparam logic signed [TIME_W-1:0] YAW_HIGH_RST   = 16'sd180;

   // Channels that carry a mapped attitude target.
   localparam logic [CHAN_OUT_W-1:0] CH_ROLL  = 4'd1;
   localparam logic [CHAN_OUT_W-1:0] CH_PITCH = 4'd2;
   localparam logic [CHAN_OUT_W-1:0] CH_YAW   = 4'd3;

   // Largest and smallest 16-bit signed values.
   localparam logic signed [TIME_W-1:0] S16_MAX = 16'sh7fff;
   localparam logic signed [TIME_W-1:0] S16_MIN = -16'sh8000;

   // Saturate a wide signed sum to 16 bits.
   function automatic logic signed [TIME_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [TIME_W-1:0] r;
      if (v > SUM_W'(32'sd32767)) begin
         r = S16_MAX;
      end else if (v < -SUM_W'(32'sd32768)) begin
         r = S16_MIN;
      end else begin
         r = v[TIME_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/ppm_frame_decoder.sv
// ----------------------------------------------------------------------------
// PPM frame decoder
// Measures the interval between falling-edge timestamps, tracks the channel
// index across sync gaps and maps the roll, pitch and yaw channels linearly
// from the count range to their target ranges.
// ----------------------------------------------------------------------------
// Sequence: a sync gap or a dropped pulse is absorbed in the idle state; a raw
// channel passes through prep and out into the output register; a mapped channel
// passes through prep, the bit-serial multiplier, the restoring divider, fin and
// out, or from prep straight to out if the count range is empty. One item is in
// work at a time; the next item is accepted once the previous result sits in the
// output register. Reset (synchronous) restores defaults, clears the index.
module ppm_frame_decoder #(
   parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ppmfd_pkg::TIME_W-1:0]          req_edge_time,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ppmfd_pkg::CHAN_OUT_W-1:0]      rsp_channel,
   output logic [ppmfd_pkg::TIME_W-1:0]          rsp_width,
   output logic signed [ppmfd_pkg::TIME_W-1:0]   rsp_target,
   output logic                                  rsp_in_range,
   output logic                                  rsp_frame_last,
   // Configuration port.
   input  logic                                  csr_write,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppmfd_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   localparam int TW     = ppmfd_pkg::TIME_W;
   localparam int PW     = ppmfd_pkg::PROD_W;
   localparam int SW     = ppmfd_pkg::SUM_W;
   localparam int CHAN_W = $clog2(NUM_CHANNELS + 1);
   localparam int CNT_W  = $clog2(PW);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(TW - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PW - 1);

   // Configuration registers.
   logic [TW-1:0]        cmin_ff, cmin_in;
   logic [TW-1:0]        cmax_ff, cmax_in;
   logic signed [TW-1:0] roll_lo_ff, roll_lo_in, roll_hi_ff, roll_hi_in;
   logic signed [TW-1:0] pitch_lo_ff, pitch_lo_in, pitch_hi_ff, pitch_hi_in;
   logic signed [TW-1:0] yaw_lo_ff, yaw_lo_in, yaw_hi_ff, yaw_hi_in;

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic [TW-1:0]        prev_ff, prev_in;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Working registers for the item in work.
   logic [TW-1:0]        w_ff, w_in;
   logic [ppmfd_pkg::CHAN_OUT_W-1:0] ch_ff, ch_in;
   logic                 inr_ff, inr_in;
   logic                 last_ff, last_in;
   logic                 neg_ff, neg_in;
   logic signed [TW-1:0] lo_ff, lo_in;
   logic [TW-1:0]        bmag_ff, bmag_in;
   logic [TW-1:0]        dmag_ff, dmag_in;
   logic [TW-1:0]        rem_ff, rem_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic signed [TW-1:0] tgt_ff, tgt_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ppmfd_pkg::CHAN_OUT_W-1:0] rsp_channel_ff, rsp_channel_in;
   logic [TW-1:0]        rsp_width_ff, rsp_width_in;
   logic signed [TW-1:0] rsp_target_ff, rsp_target_in;
   logic                 rsp_in_range_ff, rsp_in_range_in;
   logic                 rsp_frame_last_ff, rsp_frame_last_in;

   // Combinational helpers.
   logic                 accept;
   logic                 out_free;
   logic [TW-1:0]        now_w;
   logic signed [TW:0]   diff_a, diff_b, diff_d;
   logic signed [TW-1:0] sel_lo, sel_hi;
   logic                 is_map;
   logic [TW:0]          mul_sum;
   logic [TW:0]          div_trial;
   logic [TW:0]          div_part;
   logic signed [SW-1:0] lo_ext, q_ext, fin_sum;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign now_w    = req_edge_time - prev_ff;

   // Select the target range of the current channel.
   always_comb begin
      case (ch_ff)
         ppmfd_pkg::CH_ROLL: begin
            sel_lo = roll_lo_ff;
            sel_hi = roll_hi_ff;
         end
         ppmfd_pkg::CH_PITCH: begin
            sel_lo = pitch_lo_ff;
            sel_hi = pitch_hi_ff;
         end
         default: begin
            sel_lo = yaw_lo_ff;
            sel_hi = yaw_hi_ff;
         end
      endcase
   end

   // Operands of the linear map, signed 17 bits each.
   assign is_map = (ch_ff == ppmfd_pkg::CH_ROLL) || (ch_ff == ppmfd_pkg::CH_PITCH) ||
                   (ch_ff == ppmfd_pkg::CH_YAW);
   assign diff_a = $signed({1'b0, w_ff}) - $signed({1'b0, cmin_ff});
   assign diff_b = $signed({sel_hi[TW-1], sel_hi}) - $signed({sel_lo[TW-1], sel_lo});
   assign diff_d = $signed({1'b0, cmax_ff}) - $signed({1'b0, cmin_ff});

   // One multiplier bit and one quotient bit per cycle.
   assign mul_sum   = {1'b0, prod_ff[PW-1:TW]} + (prod_ff[0] ? {1'b0, bmag_ff} : '0);
   assign div_part  = {rem_ff, prod_ff[PW-1]};
   assign div_trial = div_part - {1'b0, dmag_ff};

   // Final correction: apply the sign to the quotient and add the range low.
   assign lo_ext  = SW'(lo_ff);
   assign q_ext   = $signed({2'b00, prod_ff});
   assign fin_sum = neg_ff ? (lo_ext - q_ext) : (lo_ext + q_ext);

   // Next-state logic.
   always_comb begin
      cmin_in     = cmin_ff;
      cmax_in     = cmax_ff;
      roll_lo_in  = roll_lo_ff;
      roll_hi_in  = roll_hi_ff;
      pitch_lo_in = pitch_lo_ff;
      pitch_hi_in = pitch_hi_ff;
      yaw_lo_in   = yaw_lo_ff;
      yaw_hi_in   = yaw_hi_ff;

      state_in = state_ff;
      prev_in  = prev_ff;
      chan_in  = chan_ff;
      cnt_in   = cnt_ff;
      w_in     = w_ff;
      ch_in    = ch_ff;
      inr_in   = inr_ff;
      last_in  = last_ff;
      neg_in   = neg_ff;
      lo_in    = lo_ff;
      bmag_in  = bmag_ff;
      dmag_in  = dmag_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      tgt_in   = tgt_ff;

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_channel_in    = rsp_channel_ff;
      rsp_width_in      = rsp_width_ff;
      rsp_target_in     = rsp_target_ff;
      rsp_in_range_in   = rsp_in_range_ff;
      rsp_frame_last_in = rsp_frame_last_ff;

      // Register writes.
      if (csr_write) begin
         unique case (csr_index)
            ppmfd_pkg::CSR_COUNT_MIN:  cmin_in     = csr_wdata;
            ppmfd_pkg::CSR_COUNT_MAX:  cmax_in     = csr_wdata;
            ppmfd_pkg::CSR_ROLL_LOW:   roll_lo_in  = $signed(csr_wdata);
            ppmfd_pkg::CSR_ROLL_HIGH:  roll_hi_in  = $signed(csr_wdata);
            ppmfd_pkg::CSR_PITCH_LOW:  pitch_lo_in = $signed(csr_wdata);
            ppmfd_pkg::CSR_PITCH_HIGH: pitch_hi_in = $signed(csr_wdata);
            ppmfd_pkg::CSR_YAW_LOW:    yaw_lo_in   = $signed(csr_wdata);
            ppmfd_pkg::CSR_YAW_HIGH:   yaw_hi_in   = $signed(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Measure the interval; a sync gap clears the channel index, else it advances up to NUM_CHANNELS.
            if (accept) begin
               prev_in = req_edge_time;
               if (now_w > cmax_ff) begin
                  chan_in = '0;
               end else if (chan_ff >= CHAN_W'(NUM_CHANNELS)) begin
                  chan_in = CHAN_W'(NUM_CHANNELS);
               end else begin
                  w_in     = now_w;
                  ch_in    = ppmfd_pkg::CHAN_OUT_W'(chan_ff);
                  last_in  = (chan_ff == CHAN_W'(NUM_CHANNELS - 1));
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            // Take magnitudes and signs for the serial multiply and divide, or set the target directly.
            inr_in  = (w_ff > cmin_ff) && (w_ff < cmax_ff);
            lo_in   = sel_lo;
            neg_in  = diff_a[TW] ^ diff_b[TW] ^ diff_d[TW];
            bmag_in = diff_b[TW] ? TW'(-diff_b) : diff_b[TW-1:0];
            dmag_in = diff_d[TW] ? TW'(-diff_d) : diff_d[TW-1:0];
            prod_in = {{TW{1'b0}}, (diff_a[TW] ? TW'(-diff_a) : diff_a[TW-1:0])};
            rem_in  = '0;
            cnt_in  = '0;
            if (!is_map) begin
               tgt_in   = w_ff[TW-1] ? ppmfd_pkg::S16_MAX : $signed(w_ff);
               state_in = ST_OUT;
            end else if (cmax_ff == cmin_ff) begin
               tgt_in   = sel_lo;
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Shift-add multiply, one multiplier bit per cycle.
            prod_in = {mul_sum, prod_ff[TW-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring divide, one quotient bit per cycle.
            if (!div_trial[TW]) begin
               rem_in  = div_trial[TW-1:0];
               prod_in = {prod_ff[PW-2:0], 1'b1};
            end else begin
               rem_in  = div_part[TW-1:0];
               prod_in = {prod_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            tgt_in   = ppmfd_pkg::sat16(fin_sum);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_channel_in    = ch_ff;
               rsp_width_in      = w_ff;
               rsp_target_in     = tgt_ff;
               rsp_in_range_in   = inr_ff;
               rsp_frame_last_in = last_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmin_ff      <= ppmfd_pkg::COUNT_MIN_RST;
         cmax_ff      <= ppmfd_pkg::COUNT_MAX_RST;
         roll_lo_ff   <= ppmfd_pkg::ROLL_LOW_RST;
         roll_hi_ff   <= ppmfd_pkg::ROLL_HIGH_RST;
         pitch_lo_ff  <= ppmfd_pkg::PITCH_LOW_RST;
         pitch_hi_ff  <= ppmfd_pkg::PITCH_HIGH_RST;
         yaw_lo_ff    <= ppmfd_pkg::YAW_LOW_RST;
         yaw_hi_ff    <= ppmfd_pkg::YAW_HIGH_RST;
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         chan_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmin_ff      <= cmin_in;
         cmax_ff      <= cmax_in;
         roll_lo_ff   <= roll_lo_in;
         roll_hi_ff   <= roll_hi_in;
         pitch_lo_ff  <= pitch_lo_in;
         pitch_hi_ff  <= pitch_hi_in;
         yaw_lo_ff    <= yaw_lo_in;
         yaw_hi_ff    <= yaw_hi_in;
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         chan_ff      <= chan_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_ff              <= w_in;
      ch_ff             <= ch_in;
      inr_ff            <= inr_in;
      last_ff           <= last_in;
      neg_ff            <= neg_in;
      lo_ff             <= lo_in;
      bmag_ff           <= bmag_in;
      dmag_ff           <= dmag_in;
      rem_ff            <= rem_in;
      prod_ff           <= prod_in;
      tgt_ff            <= tgt_in;
      rsp_channel_ff    <= rsp_channel_in;
      rsp_width_ff      <= rsp_width_in;
      rsp_target_ff     <= rsp_target_in;
      rsp_in_range_ff   <= rsp_in_range_in;
      rsp_frame_last_ff <= rsp_frame_last_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_width      = rsp_width_ff;
   assign rsp_target     = rsp_target_ff;
   assign rsp_in_range   = rsp_in_range_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule
